// ----- hdl/chgs_pkg.sv -----
// Shared constants for the Graham scan convex hull unit.
`default_nettype none
package chgs_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W        = 16;
	localparam int PT_W           = 2 * COORD_W;
	localparam int DIFF_W         = COORD_W + 1;
	localparam int PROD_W         = 2 * DIFF_W;
endpackage
`default_nettype wire

// ----- hdl/chgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chgs_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/convex_hull_graham_scan_unit.sv -----
// Top level of the Graham scan convex hull unit.
//
// Points enter on the input channel (in_valid/in_ready), one beat per point,
// up to MAX_POINTS per set; extra points are dropped. The beat with
// last_point set closes the set. The unit then drops in_ready, sorts the
// points by angle around the pivot (lowest y, first seen) with an insertion
// sort, runs the Graham scan and sends the hull counterclockwise from the
// pivot on the output channel (out_valid/out_ready), hull_last on the final
// vertex. Sets of fewer than three points come back unchanged.
// Loading accepts one point per cycle. Each sort compare costs one RAM read
// and two passes through the one 17x17 multiplier, up to n*n/2 compares;
// the sort loop around the multiplier sets the run time of a large set.
// A stalled receiver holds the current vertex; the unit waits. Reset returns
// to loading with an empty set; no clearing pass is needed.
`default_nettype none
module convex_hull_graham_scan_unit #(
	parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [chgs_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [chgs_pkg::COORD_W-1:0] point_y,
	input  wire logic                                last_point,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [chgs_pkg::COORD_W-1:0]      hull_x,
	output logic signed [chgs_pkg::COORD_W-1:0]      hull_y,
	output logic                                     hull_last
);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int PW = chgs_pkg::PT_W;
	localparam int XW = chgs_pkg::COORD_W;
	localparam int DW = chgs_pkg::DIFF_W;
	localparam int MW = chgs_pkg::PROD_W;

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_SI    = 5'd1;
	localparam logic [4:0] S_SI_W  = 5'd2;
	localparam logic [4:0] S_SJ    = 5'd3;
	localparam logic [4:0] S_SJ_W  = 5'd4;
	localparam logic [4:0] S_CMP1  = 5'd5;
	localparam logic [4:0] S_CMP2  = 5'd6;
	localparam logic [4:0] S_CMP3  = 5'd7;
	localparam logic [4:0] S_H0    = 5'd8;
	localparam logic [4:0] S_H1    = 5'd9;
	localparam logic [4:0] S_H2    = 5'd10;
	localparam logic [4:0] S_SC_I  = 5'd11;
	localparam logic [4:0] S_SC_W  = 5'd12;
	localparam logic [4:0] S_T1    = 5'd13;
	localparam logic [4:0] S_T2    = 5'd14;
	localparam logic [4:0] S_T3    = 5'd15;
	localparam logic [4:0] S_POPW  = 5'd16;
	localparam logic [4:0] S_PUSH  = 5'd17;
	localparam logic [4:0] S_EM_RD = 5'd18;
	localparam logic [4:0] S_EM_W  = 5'd19;
	localparam logic [4:0] S_EM_HD = 5'd20;

	logic [4:0]           state_q;
	logic [CW-1:0]        cnt_q, n_q, i_q, j_q, m_q, top_q, e_q, lim_q;
	logic [IW-1:0]        piv_idx_q;
	logic signed [XW-1:0] piv_x_q, piv_y_q;
	logic                 src_stack_q;
	logic [PW-1:0]        a_q, b_q, t1_q, t2_q;
	logic signed [MW-1:0] prod1_q, prod2_q;

	logic                 pt_we, ord_we, stk_we;
	logic [IW-1:0]        pt_raddr, ord_waddr, ord_raddr, stk_waddr, stk_raddr;
	logic [PW-1:0]        ord_wdata, stk_wdata, pt_rdata, ord_rdata, stk_rdata;

	logic signed [DW-1:0] adx, ady, bdx, bdy, x1, y1, x2, y2, mul_a, mul_b;
	logic signed [MW-1:0] mul_p;
	logic signed [MW:0]   diff;
	logic [1:0]           ra, rb;
	logic                 a_first, in_acc, store_ok;
	logic [CW-1:0]        n_new;

	function automatic logic signed [DW-1:0] sub_c(input logic [XW-1:0] p,
			input logic [XW-1:0] q);
		return $signed({p[XW-1], p}) - $signed({q[XW-1], q});
	endfunction

	function automatic logic [1:0] rank(input logic signed [DW-1:0] dx,
			input logic signed [DW-1:0] dy);
		if (dy != '0) begin
			return 2'd1;
		end
		return dx[DW-1] ? 2'd2 : 2'd0;
	endfunction

	assign in_ready = (state_q == S_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign store_ok = (cnt_q < CW'(MAX_POINTS));
	assign n_new    = store_ok ? cnt_q + CW'(1) : cnt_q;

	always_comb begin
		adx = sub_c(a_q[PW-1:XW], piv_x_q);
		ady = sub_c(a_q[XW-1:0], piv_y_q);
		bdx = sub_c(b_q[PW-1:XW], piv_x_q);
		bdy = sub_c(b_q[XW-1:0], piv_y_q);
		x1  = sub_c(t1_q[PW-1:XW], t2_q[PW-1:XW]);
		y1  = sub_c(t1_q[XW-1:0], t2_q[XW-1:0]);
		x2  = sub_c(a_q[PW-1:XW], t2_q[PW-1:XW]);
		y2  = sub_c(a_q[XW-1:0], t2_q[XW-1:0]);
		case (state_q)
			S_CMP1: begin
				mul_a = adx;
				mul_b = bdy;
			end
			S_CMP2: begin
				mul_a = bdx;
				mul_b = ady;
			end
			S_T1: begin
				mul_a = x1;
				mul_b = y2;
			end
			default: begin
				mul_a = x2;
				mul_b = y1;
			end
		endcase
		mul_p = mul_a * mul_b;
		diff  = $signed({prod1_q[MW-1], prod1_q}) - $signed({prod2_q[MW-1], prod2_q});
		ra    = rank(adx, ady);
		rb    = rank(bdx, bdy);
		if (ra != rb) begin
			a_first = (ra < rb);
		end else if (ra == 2'd1 && diff != '0) begin
			a_first = !diff[MW];
		end else if (a_q[PW-1:XW] != b_q[PW-1:XW]) begin
			a_first = $signed(a_q[PW-1:XW]) < $signed(b_q[PW-1:XW]);
		end else begin
			a_first = $signed(a_q[XW-1:0]) < $signed(b_q[XW-1:0]);
		end
	end

	// RAM port steering
	always_comb begin
		pt_we     = in_acc && store_ok;
		pt_raddr  = (state_q == S_SI) ? i_q[IW-1:0] : e_q[IW-1:0];
		ord_we    = 1'b0;
		ord_waddr = j_q[IW-1:0];
		ord_wdata = a_q;
		ord_raddr = i_q[IW-1:0];
		stk_we    = 1'b0;
		stk_waddr = top_q[IW-1:0];
		stk_wdata = a_q;
		stk_raddr = e_q[IW-1:0];
		case (state_q)
			S_SJ: begin
				ord_we    = (j_q == '0);
				ord_raddr = IW'(j_q - CW'(1));
			end
			S_CMP3: begin
				ord_we    = 1'b1;
				ord_wdata = a_first ? b_q : a_q;
			end
			S_H0: begin
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = {piv_x_q, piv_y_q};
				ord_raddr = '0;
			end
			S_H1: begin
				stk_we    = 1'b1;
				stk_waddr = IW'(1);
				stk_wdata = ord_rdata;
				ord_raddr = IW'(1);
			end
			S_H2: begin
				stk_we    = 1'b1;
				stk_waddr = IW'(2);
				stk_wdata = ord_rdata;
			end
			S_T3: begin
				stk_raddr = IW'(top_q - CW'(3));
			end
			S_PUSH: begin
				stk_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	chgs_ram #(.W(PW), .D(MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(cnt_q[IW-1:0]), .wdata({point_x, point_y}),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	chgs_ram #(.W(PW), .D(MAX_POINTS)) u_ord_ram (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	chgs_ram #(.W(PW), .D(MAX_POINTS)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			m_q         <= '0;
			top_q       <= '0;
			e_q         <= '0;
			lim_q       <= '0;
			piv_idx_q   <= '0;
			piv_x_q     <= '0;
			piv_y_q     <= '0;
			src_stack_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (store_ok && (cnt_q == '0 || point_y < piv_y_q)) begin
							piv_idx_q <= cnt_q[IW-1:0];
							piv_x_q   <= point_x;
							piv_y_q   <= point_y;
						end
						if (last_point) begin
							cnt_q <= '0;
							n_q   <= n_new;
							i_q   <= '0;
							m_q   <= '0;
							e_q   <= '0;
							if (n_new < CW'(3)) begin
								src_stack_q <= 1'b0;
								lim_q       <= n_new;
								state_q     <= S_EM_RD;
							end else begin
								state_q <= S_SI;
							end
						end else begin
							cnt_q <= n_new;
						end
					end
				end
				S_SI: begin
					if (i_q == n_q) begin
						state_q <= S_H0;
					end else if (i_q == CW'(piv_idx_q)) begin
						i_q <= i_q + CW'(1);
					end else begin
						state_q <= S_SI_W;
					end
				end
				S_SI_W: begin
					a_q     <= pt_rdata;
					j_q     <= m_q;
					state_q <= S_SJ;
				end
				S_SJ: begin
					if (j_q == '0) begin
						m_q     <= m_q + CW'(1);
						i_q     <= i_q + CW'(1);
						state_q <= S_SI;
					end else begin
						state_q <= S_SJ_W;
					end
				end
				S_SJ_W: begin
					b_q     <= ord_rdata;
					state_q <= S_CMP1;
				end
				S_CMP1: begin
					prod1_q <= mul_p;
					state_q <= S_CMP2;
				end
				S_CMP2: begin
					prod2_q <= mul_p;
					state_q <= S_CMP3;
				end
				S_CMP3: begin
					// shift the larger entry up, or drop the new point in place
					if (a_first) begin
						j_q     <= j_q - CW'(1);
						state_q <= S_SJ;
					end else begin
						m_q     <= m_q + CW'(1);
						i_q     <= i_q + CW'(1);
						state_q <= S_SI;
					end
				end
				S_H0: begin
					state_q <= S_H1;
				end
				S_H1: begin
					t2_q    <= ord_rdata;
					state_q <= S_H2;
				end
				S_H2: begin
					t1_q    <= ord_rdata;
					top_q   <= CW'(3);
					i_q     <= CW'(2);
					state_q <= S_SC_I;
				end
				S_SC_I: begin
					if (i_q == m_q) begin
						src_stack_q <= 1'b1;
						lim_q       <= top_q;
						e_q         <= '0;
						state_q     <= S_EM_RD;
					end else begin
						state_q <= S_SC_W;
					end
				end
				S_SC_W: begin
					a_q     <= ord_rdata;
					state_q <= S_T1;
				end
				S_T1: begin
					prod1_q <= mul_p;
					state_q <= (top_q < CW'(2)) ? S_PUSH : S_T2;
				end
				S_T2: begin
					prod2_q <= mul_p;
					state_q <= S_T3;
				end
				S_T3: begin
					// pop on a strictly clockwise turn
					if (diff[MW]) begin
						top_q <= top_q - CW'(1);
						t1_q  <= t2_q;
						state_q <= (top_q >= CW'(3)) ? S_POPW : S_T1;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_POPW: begin
					t2_q    <= stk_rdata;
					state_q <= S_T1;
				end
				S_PUSH: begin
					t2_q    <= t1_q;
					t1_q    <= a_q;
					top_q   <= top_q + CW'(1);
					i_q     <= i_q + CW'(1);
					state_q <= S_SC_I;
				end
				S_EM_RD: begin
					if (e_q == lim_q) begin
						piv_idx_q <= '0;
						state_q   <= S_LOAD;
					end else begin
						state_q <= S_EM_W;
					end
				end
				S_EM_W: begin
					hull_x    <= src_stack_q ? stk_rdata[PW-1:XW] : pt_rdata[PW-1:XW];
					hull_y    <= src_stack_q ? stk_rdata[XW-1:0] : pt_rdata[XW-1:0];
					hull_last <= (e_q + CW'(1) == lim_q);
					out_valid <= 1'b1;
					e_q       <= e_q + CW'(1);
					state_q   <= S_EM_HD;
				end
				S_EM_HD: begin
					// hold the vertex until the receiver takes the beat
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_EM_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
